[hw/rtl/mmep_pkg.sv]
// ----------------------------------------------------------------------------
// mmep_pkg
// Shared types, constants and helpers of the min/max envelope pyramid.
// ----------------------------------------------------------------------------
package mmep_pkg;

  // Stream geometry
  localparam int MAX_CHANNELS  = 4;
  localparam int WINDOW_FRAMES = 8;
  localparam int LEVELS        = 10;

  // Field widths
  localparam int SMP_W  = 16;
  localparam int CH_W   = 2;
  localparam int LVL_W  = 4;
  localparam int CHN_W  = 3;
  localparam int FIW_W  = $clog2(WINDOW_FRAMES);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT   = 1'd1;
  localparam logic [CHN_W-1:0] CHANNEL_COUNT_RST = 3'd1;
  localparam logic [LVL_W-1:0] LEVEL_COUNT_RST   = 4'd10;

  // Pending-point store: one entry per level and channel, {min, max}
  localparam int PEND_DEPTH = LEVELS * MAX_CHANNELS;
  localparam int PEND_AW    = $clog2(PEND_DEPTH);
  localparam int PEND_W     = 2 * SMP_W;

  // Results caused by one input word are capped at this count
  localparam int RES_LIMIT = LEVELS * MAX_CHANNELS;
  localparam int RES_CNT_W = $clog2(RES_LIMIT + 1);

  // Running extremes reset values
  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [LVL_W-1:0]        level;
    logic [CH_W-1:0]         channel;
    logic signed [SMP_W-1:0] min_value;
    logic signed [SMP_W-1:0] max_value;
    logic                    last;
  } out_word_t;

  // Store address of the pending point of a level and channel
  function automatic logic [PEND_AW-1:0] pend_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [CH_W-1:0] ch);
    int a;
    a = int'(lvl) * MAX_CHANNELS + int'(ch);
    return a[PEND_AW-1:0];
  endfunction

endpackage

[hw/rtl/min_max_envelope_pyramid.sv]
// ----------------------------------------------------------------------------
// min_max_envelope_pyramid
// Per-channel min/max waveform envelope with a pyramid of merged levels.
// ----------------------------------------------------------------------------
// Input words carry one signed sample each, channels interleaved; a word with
// end_of_stream set closes the stream. Output words are envelope points
// (level, channel, min, max); last marks the final point caused by one input
// word. Both channels use valid/stall; cfg_wr_en writes channel_count
// (index 0) or level_count (index 1) and must only be used while idle.
// A word that closes no window leaves the block idle for the next word. A word
// that closes a window or ends the stream holds the input off while each
// channel's point is emitted and walked up the pyramid, and at end of stream
// while the pending points are scanned per level and channel; each pyramid
// step is a read of the pending-point RAM followed by a merge cycle, and that
// read/merge loop sets the rate. At most 40 points per word.
// Reset (synchronous, rst_n low) clears all stream state and sets
// channel_count to 1 and level_count to 10; no clearing pass is needed since
// the pending points carry valid flops. A stalled receiver holds the output
// word; the pyramid walk then waits in its merge cycle until the word moves.
// ----------------------------------------------------------------------------
module min_max_envelope_pyramid (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  mmep_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output mmep_pkg::out_word_t                  out_data,
  input  logic                                 cfg_wr_en,
  input  logic [mmep_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmep_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WLD   = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_FSCAN = 3'd4;
  localparam logic [2:0] ST_FLOAD = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam int SW = mmep_pkg::SMP_W;
  localparam int NC = mmep_pkg::MAX_CHANNELS;

  logic [2:0] state_r, state_nxt;
  logic [mmep_pkg::CHN_W-1:0] chan_cnt_r, chan_cnt_nxt;
  logic [mmep_pkg::LVL_W-1:0] lvl_cnt_r, lvl_cnt_nxt;
  logic [mmep_pkg::CH_W-1:0]  next_ch_r, next_ch_nxt;
  logic [mmep_pkg::FIW_W-1:0] fiw_r, fiw_nxt;
  logic signed [SW-1:0] run_min_r [NC];
  logic signed [SW-1:0] run_min_nxt [NC];
  logic signed [SW-1:0] run_max_r [NC];
  logic signed [SW-1:0] run_max_nxt [NC];
  logic signed [SW-1:0] frame_r [NC];
  logic signed [SW-1:0] frame_nxt [NC];
  logic [mmep_pkg::PEND_DEPTH-1:0] pend_vld_r, pend_vld_nxt;
  logic win_r, win_nxt;
  logic eos_r, eos_nxt;
  logic flushing_r, flushing_nxt;
  logic [mmep_pkg::CH_W-1:0]  ch_r, ch_nxt;
  logic [mmep_pkg::LVL_W-1:0] lvl_r, lvl_nxt;
  logic [mmep_pkg::LVL_W-1:0] fl_lvl_r, fl_lvl_nxt;
  logic [mmep_pkg::RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [SW-1:0] cur_min_r, cur_min_nxt;
  logic signed [SW-1:0] cur_max_r, cur_max_nxt;
  mmep_pkg::out_word_t stg_r, stg_nxt;
  logic stg_vld_r, stg_vld_nxt;
  mmep_pkg::out_word_t out_r, out_nxt;
  logic out_vld_r, out_vld_nxt;

  logic [mmep_pkg::CHN_W-1:0] chans;
  logic [mmep_pkg::LVL_W-1:0] top_lvl;
  logic [mmep_pkg::CH_W-1:0]  acc_ch;
  logic                       frame_done;
  logic                       win_close;
  logic [mmep_pkg::FIW_W-1:0] fiw_after;
  logic                       can_push;
  logic                       more_ch;
  logic                       fin_go;
  logic signed [SW-1:0]       rd_min, rd_max;

  logic                          ram_we, ram_re;
  logic [mmep_pkg::PEND_AW-1:0]  ram_waddr, ram_raddr;
  logic [mmep_pkg::PEND_W-1:0]   ram_wdata, ram_rdata;

  // Pending-point store
  mmep_ram #(
    .WIDTH (mmep_pkg::PEND_W),
    .DEPTH (mmep_pkg::PEND_DEPTH)
  ) u_pend_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Clamp the configuration to its working range
  always_comb begin
    logic [mmep_pkg::LVL_W-1:0] lvl_eff;
    if (chan_cnt_r == '0) begin
      chans = mmep_pkg::CHN_W'(1);
    end else if (chan_cnt_r > mmep_pkg::CHN_W'(NC)) begin
      chans = mmep_pkg::CHN_W'(NC);
    end else begin
      chans = chan_cnt_r;
    end
    if (lvl_cnt_r == '0) begin
      lvl_eff = mmep_pkg::LVL_W'(1);
    end else if (lvl_cnt_r > mmep_pkg::LVL_W'(mmep_pkg::LEVELS)) begin
      lvl_eff = mmep_pkg::LVL_W'(mmep_pkg::LEVELS);
    end else begin
      lvl_eff = lvl_cnt_r;
    end
    top_lvl = lvl_eff - mmep_pkg::LVL_W'(1);
  end

  // Frame position of the incoming word
  assign acc_ch     = ({1'b0, next_ch_r} >= chans) ? '0 : next_ch_r;
  assign frame_done = ({1'b0, acc_ch} + mmep_pkg::CHN_W'(1)) >= chans;
  assign win_close  = frame_done &&
                      (fiw_r == mmep_pkg::FIW_W'(mmep_pkg::WINDOW_FRAMES - 1));
  assign fiw_after  = !frame_done ? fiw_r :
                      (win_close ? '0 : fiw_r + mmep_pkg::FIW_W'(1));

  assign can_push = !out_vld_r || !out_stall;
  assign more_ch  = ({1'b0, ch_r} + mmep_pkg::CHN_W'(1)) < chans;
  assign fin_go   = !stg_vld_r || can_push;
  assign rd_min   = ram_rdata[mmep_pkg::PEND_W-1:SW];
  assign rd_max   = ram_rdata[SW-1:0];

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Sequencer: window emission, pyramid walk and end-of-stream flush
  always_comb begin
    logic [mmep_pkg::PEND_AW-1:0] a_cur;
    logic [mmep_pkg::PEND_AW-1:0] a_fl;
    logic                         push_done;
    logic signed [SW-1:0]         cand;

    state_nxt    = state_r;
    chan_cnt_nxt = chan_cnt_r;
    lvl_cnt_nxt  = lvl_cnt_r;
    next_ch_nxt  = next_ch_r;
    fiw_nxt      = fiw_r;
    run_min_nxt  = run_min_r;
    run_max_nxt  = run_max_r;
    frame_nxt    = frame_r;
    pend_vld_nxt = pend_vld_r;
    win_nxt      = win_r;
    eos_nxt      = eos_r;
    flushing_nxt = flushing_r;
    ch_nxt       = ch_r;
    lvl_nxt      = lvl_r;
    fl_lvl_nxt   = fl_lvl_r;
    cnt_nxt      = cnt_r;
    cur_min_nxt  = cur_min_r;
    cur_max_nxt  = cur_max_r;
    stg_nxt      = stg_r;
    stg_vld_nxt  = stg_vld_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && out_stall;
    push_done    = 1'b0;
    cand         = '0;

    a_cur     = mmep_pkg::pend_addr(lvl_r, ch_r);
    a_fl      = mmep_pkg::pend_addr(fl_lvl_r, ch_r);
    ram_we    = 1'b0;
    ram_waddr = a_cur;
    ram_wdata = {cur_min_r, cur_max_r};
    ram_re    = 1'b0;
    ram_raddr = a_cur;

    // Register writes
    if (cfg_wr_en) begin
      unique case (cfg_index)
        mmep_pkg::CFG_CHANNEL_COUNT: chan_cnt_nxt = cfg_data[mmep_pkg::CHN_W-1:0];
        mmep_pkg::CFG_LEVEL_COUNT:   lvl_cnt_nxt  = cfg_data[mmep_pkg::LVL_W-1:0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // Take the sample; fold a completed frame into the running extremes
          frame_nxt[acc_ch] = in_data.sample;
          if (frame_done) begin
            for (int c = 0; c < NC; c++) begin
              cand = (c == int'(acc_ch)) ? in_data.sample : frame_r[c];
              if (mmep_pkg::CHN_W'(c) < chans) begin
                if (cand < run_min_r[c]) run_min_nxt[c] = cand;
                if (cand > run_max_r[c]) run_max_nxt[c] = cand;
              end
            end
            next_ch_nxt = '0;
          end else begin
            next_ch_nxt = acc_ch + mmep_pkg::CH_W'(1);
          end
          fiw_nxt      = fiw_after;
          win_nxt      = win_close;
          eos_nxt      = in_data.end_of_stream;
          flushing_nxt = 1'b0;
          ch_nxt       = '0;
          fl_lvl_nxt   = '0;
          cnt_nxt      = '0;
          if (in_data.end_of_stream) begin
            next_ch_nxt = '0;
            fiw_nxt     = '0;
            for (int c = 0; c < NC; c++) begin
              frame_nxt[c] = '0;
            end
          end
          if (win_close || (in_data.end_of_stream && fiw_after != '0)) begin
            state_nxt = ST_WLD;
          end else if (in_data.end_of_stream) begin
            flushing_nxt = 1'b1;
            state_nxt    = ST_FSCAN;
          end
        end
      end

      ST_WLD: begin
        // Start a level-0 point from the window extremes of this channel
        cur_min_nxt = run_min_r[ch_r];
        cur_max_nxt = run_max_r[ch_r];
        lvl_nxt     = '0;
        state_nxt   = ST_RD;
      end

      ST_RD: begin
        ram_re    = 1'b1;
        ram_raddr = a_cur;
        state_nxt = ST_STEP;
      end

      ST_STEP: begin
        if (cnt_r >= mmep_pkg::RES_CNT_W'(mmep_pkg::RES_LIMIT) || fin_go) begin
          // Emit the current point through the staging word
          if (cnt_r < mmep_pkg::RES_CNT_W'(mmep_pkg::RES_LIMIT)) begin
            if (stg_vld_r) begin
              out_nxt      = stg_r;
              out_nxt.last = 1'b0;
              out_vld_nxt  = 1'b1;
            end
            stg_nxt.level     = lvl_r;
            stg_nxt.channel   = ch_r;
            stg_nxt.min_value = cur_min_r;
            stg_nxt.max_value = cur_max_r;
            stg_nxt.last      = 1'b0;
            stg_vld_nxt       = 1'b1;
            cnt_nxt           = cnt_r + mmep_pkg::RES_CNT_W'(1);
          end
          // Merge with the pending point, or park this one
          if (lvl_r >= top_lvl) begin
            push_done = 1'b1;
          end else if (pend_vld_r[a_cur]) begin
            if (rd_min < cur_min_r) cur_min_nxt = rd_min;
            if (rd_max > cur_max_r) cur_max_nxt = rd_max;
            pend_vld_nxt[a_cur] = 1'b0;
            lvl_nxt             = lvl_r + mmep_pkg::LVL_W'(1);
            state_nxt           = ST_RD;
          end else begin
            ram_we              = 1'b1;
            pend_vld_nxt[a_cur] = 1'b1;
            push_done           = 1'b1;
          end
          if (push_done) begin
            if (flushing_r) begin
              fl_lvl_nxt = fl_lvl_r + mmep_pkg::LVL_W'(1);
              state_nxt  = ST_FSCAN;
            end else if (more_ch) begin
              ch_nxt    = ch_r + mmep_pkg::CH_W'(1);
              state_nxt = ST_WLD;
            end else if (eos_r) begin
              flushing_nxt = 1'b1;
              ch_nxt       = '0;
              fl_lvl_nxt   = '0;
              state_nxt    = ST_FSCAN;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        end
      end

      ST_FSCAN: begin
        // Walk the pending points of each channel, lowest level first
        if (fl_lvl_r < top_lvl) begin
          if (pend_vld_r[a_fl]) begin
            ram_re             = 1'b1;
            ram_raddr          = a_fl;
            pend_vld_nxt[a_fl] = 1'b0;
            state_nxt          = ST_FLOAD;
          end else begin
            fl_lvl_nxt = fl_lvl_r + mmep_pkg::LVL_W'(1);
          end
        end else if (more_ch) begin
          ch_nxt     = ch_r + mmep_pkg::CH_W'(1);
          fl_lvl_nxt = '0;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_FLOAD: begin
        // Carry the pending point up one level
        cur_min_nxt = rd_min;
        cur_max_nxt = rd_max;
        lvl_nxt     = fl_lvl_r + mmep_pkg::LVL_W'(1);
        state_nxt   = ST_RD;
      end

      ST_FIN: begin
        if (fin_go) begin
          // Release the final point with last set and drop stream state
          if (stg_vld_r) begin
            out_nxt      = stg_r;
            out_nxt.last = 1'b1;
            out_vld_nxt  = 1'b1;
          end
          stg_vld_nxt = 1'b0;
          if (win_r || eos_r) begin
            for (int c = 0; c < NC; c++) begin
              run_min_nxt[c] = mmep_pkg::SMP_MAX;
              run_max_nxt[c] = mmep_pkg::SMP_MIN;
            end
          end
          if (eos_r) begin
            pend_vld_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      chan_cnt_r <= mmep_pkg::CHANNEL_COUNT_RST;
      lvl_cnt_r  <= mmep_pkg::LEVEL_COUNT_RST;
      next_ch_r  <= '0;
      fiw_r      <= '0;
      for (int c = 0; c < NC; c++) begin
        run_min_r[c] <= mmep_pkg::SMP_MAX;
        run_max_r[c] <= mmep_pkg::SMP_MIN;
        frame_r[c]   <= '0;
      end
      pend_vld_r <= '0;
      win_r      <= 1'b0;
      eos_r      <= 1'b0;
      flushing_r <= 1'b0;
      ch_r       <= '0;
      lvl_r      <= '0;
      fl_lvl_r   <= '0;
      cnt_r      <= '0;
      stg_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      chan_cnt_r <= chan_cnt_nxt;
      lvl_cnt_r  <= lvl_cnt_nxt;
      next_ch_r  <= next_ch_nxt;
      fiw_r      <= fiw_nxt;
      run_min_r  <= run_min_nxt;
      run_max_r  <= run_max_nxt;
      frame_r    <= frame_nxt;
      pend_vld_r <= pend_vld_nxt;
      win_r      <= win_nxt;
      eos_r      <= eos_nxt;
      flushing_r <= flushing_nxt;
      ch_r       <= ch_nxt;
      lvl_r      <= lvl_nxt;
      fl_lvl_r   <= fl_lvl_nxt;
      cnt_r      <= cnt_nxt;
      stg_vld_r  <= stg_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_min_r <= cur_min_nxt;
    cur_max_r <= cur_max_nxt;
    stg_r     <= stg_nxt;
    out_r     <= out_nxt;
  end

`ifndef SYNTHESIS
  // No point may be left in staging once the block is idle
  a_stg_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !stg_vld_r)
    else $error("staging word left over in idle");

  // The pyramid walk never climbs past the top level
  a_lvl_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (lvl_r <= top_lvl))
    else $error("pyramid walk beyond top level");

  // End of stream leaves no pending point behind
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && fin_go && eos_r) |=> (pend_vld_r == '0))
    else $error("pending points survive end of stream");

  // The word count of one input stays within the cap
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= mmep_pkg::RES_CNT_W'(mmep_pkg::RES_LIMIT)))
    else $error("result count beyond cap");
`endif

endmodule

[hw/rtl/mmep_ram.sv]
// ----------------------------------------------------------------------------
// mmep_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mmep_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word; hold it when no read is issued
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the min/max envelope pyramid. A scripted opening
// walks sample extremes, end-of-stream flushes, out-of-range register values,
// a channel count lowered mid-frame and an end marker on a window boundary.
// Random streams follow: whole or partial windows of random samples, some
// broken frames, open streams and noise. Each result word is checked against
// an in-bench predictor of the envelope state while both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import mmep_pkg::*;

  localparam int SETTLE_CYCLES = 256;
  localparam int RANDOM_WORDS  = 160;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    in_word_t              w;
    logic                  typed;
    out_word_t             want;
  } script_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Random idling is switched off while this is set
  logic calm = 1'b0;

  int words_sent     = 0;
  int points_checked = 0;
  int reg_writes     = 0;
  int errors         = 0;
  int deepest        = 0;

  // Predictor state: register copies, frame position, running extremes,
  // pending points per level and channel
  logic [CHN_W-1:0]        chan_reg_m;
  logic [LVL_W-1:0]        lvl_reg_m;
  int                      slot_m;
  int                      frames_m;
  logic signed [SMP_W-1:0] lo_m    [MAX_CHANNELS];
  logic signed [SMP_W-1:0] hi_m    [MAX_CHANNELS];
  logic signed [SMP_W-1:0] frame_m [MAX_CHANNELS];
  logic                    held_v  [LEVELS][MAX_CHANNELS];
  logic signed [SMP_W-1:0] held_lo [LEVELS][MAX_CHANNELS];
  logic signed [SMP_W-1:0] held_hi [LEVELS][MAX_CHANNELS];

  out_word_t   points_due[$];
  out_word_t   fresh_pts[$];
  script_row_t script[$];

  min_max_envelope_pyramid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic out_word_t mk_point(input int lvl, input int ch,
                                         input logic signed [SMP_W-1:0] lo,
                                         input logic signed [SMP_W-1:0] hi,
                                         input logic last_f);
    out_word_t p;
    p.level     = LVL_W'(lvl);
    p.channel   = CH_W'(ch);
    p.min_value = lo;
    p.max_value = hi;
    p.last      = last_f;
    return p;
  endfunction

  function automatic int active_channels();
    int n;
    n = int'(chan_reg_m);
    if (n < 1) n = 1;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    return n;
  endfunction

  function automatic void clear_envelope();
    slot_m   = 0;
    frames_m = 0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      lo_m[c]    = SMP_MAX;
      hi_m[c]    = SMP_MIN;
      frame_m[c] = '0;
      for (int l = 0; l < LEVELS; l++) begin
        held_v[l][c]  = 1'b0;
        held_lo[l][c] = '0;
        held_hi[l][c] = '0;
      end
    end
  endfunction

  // Emit a point, then merge it upward while its level holds a pending partner
  function automatic void climb(input int lvl, input int ch,
                                input logic signed [SMP_W-1:0] lo,
                                input logic signed [SMP_W-1:0] hi,
                                input int top);
    logic done;
    done = 1'b0;
    while (!done) begin
      if (fresh_pts.size() < RES_LIMIT) fresh_pts.push_back(mk_point(lvl, ch, lo, hi, 1'b0));
      if (lvl >= top) begin
        done = 1'b1;
      end else if (held_v[lvl][ch]) begin
        if (held_lo[lvl][ch] < lo) lo = held_lo[lvl][ch];
        if (held_hi[lvl][ch] > hi) hi = held_hi[lvl][ch];
        held_v[lvl][ch] = 1'b0;
        lvl++;
      end else begin
        held_v[lvl][ch]  = 1'b1;
        held_lo[lvl][ch] = lo;
        held_hi[lvl][ch] = hi;
        done = 1'b1;
      end
    end
  endfunction

  function automatic void close_window(input int chans, input int top);
    for (int c = 0; c < chans; c++) climb(0, c, lo_m[c], hi_m[c], top);
  endfunction

  // Work out the points caused by one sample word into fresh_pts
  function automatic void predict_points(input in_word_t w);
    int chans, levels, top, ch;
    logic signed [SMP_W-1:0] lo, hi;
    chans  = active_channels();
    levels = int'(lvl_reg_m);
    if (levels < 1) levels = 1;
    if (levels > LEVELS) levels = LEVELS;
    top = levels - 1;
    fresh_pts.delete();

    // Drop a partial frame that no longer fits the channel count
    ch = slot_m;
    if (ch >= chans) ch = 0;
    frame_m[ch] = w.sample;
    if (ch + 1 >= chans) begin
      for (int c = 0; c < chans; c++) begin
        if (frame_m[c] < lo_m[c]) lo_m[c] = frame_m[c];
        if (frame_m[c] > hi_m[c]) hi_m[c] = frame_m[c];
      end
      slot_m = 0;
      frames_m++;
      if (frames_m >= WINDOW_FRAMES) begin
        close_window(chans, top);
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          lo_m[c] = SMP_MAX;
          hi_m[c] = SMP_MIN;
        end
        frames_m = 0;
      end
    end else begin
      slot_m = ch + 1;
    end

    // Flush the partial window and copy up every odd pending point
    if (w.end_of_stream) begin
      if (frames_m > 0) close_window(chans, top);
      for (int c = 0; c < chans; c++) begin
        for (int l = 0; l < top; l++) begin
          if (held_v[l][c]) begin
            lo = held_lo[l][c];
            hi = held_hi[l][c];
            held_v[l][c] = 1'b0;
            climb(l + 1, c, lo, hi, top);
          end
        end
      end
      clear_envelope();
    end

    if (fresh_pts.size() > 0) fresh_pts[fresh_pts.size() - 1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------------ drivers

  function automatic logic signed [SMP_W-1:0] pick_sample();
    logic [SMP_W-1:0] r;
    r = SMP_W'($urandom);
    case ($urandom_range(0, 7))
      0: r = SMP_MIN;
      1: r = SMP_MAX;
      2: r = {{8{r[7]}}, r[7:0]};
      default: ;
    endcase
    return r;
  endfunction

  // Hold valid low until every expected point has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (points_due.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_CHANNEL_COUNT) chan_reg_m = val[CHN_W-1:0];
    else lvl_reg_m = val[LVL_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // Offer one word, wait for it to be taken, then queue what it causes
  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    if (!calm && $urandom_range(0, 39) == 0) begin
      drain();
    end else if (!calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    predict_points(w);
    if (typed) points_due.push_back(want);
    else foreach (fresh_pts[i]) points_due.push_back(fresh_pts[i]);
  endtask

  task automatic run_stream();
    int chans, frames, count, mode, i;
    in_word_t w;
    chans  = active_channels();
    mode   = $urandom_range(0, 9);
    frames = ($urandom_range(0, 2) == 0) ? 8 * $urandom_range(1, 2) : $urandom_range(1, 12);
    count  = frames * chans;
    // broken stream: part of a frame before the end marker
    if (mode == 0 && chans > 1) count += $urandom_range(1, chans - 1);
    // noise: short burst with scattered end markers
    if (mode == 1) count = $urandom_range(1, 10);
    for (i = 0; i < count; i++) begin
      w.sample = pick_sample();
      if (mode == 1) w.end_of_stream = ($urandom_range(0, 5) == 0);
      else w.end_of_stream = (mode != 2) && (i == count - 1);  // leave open on mode 2
      send_word(w, 1'b0, '0);
    end
  endtask

  function automatic script_row_t word_row(input logic signed [SMP_W-1:0] s,
                                           input logic eos);
    script_row_t r;
    r = '0;
    r.kind            = ROW_WORD;
    r.w.sample        = s;
    r.w.end_of_stream = eos;
    return r;
  endfunction

  function automatic script_row_t typed_row(input logic signed [SMP_W-1:0] s,
                                            input logic eos, input out_word_t want);
    script_row_t r;
    r = word_row(s, eos);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    script_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic flag(input string what, input out_word_t got, input out_word_t want);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("ERROR %s at %0t: level %0d/%0d ch %0d/%0d min %0d/%0d max %0d/%0d last %0b/%0b (got/want)",
               what, $time, got.level, want.level, got.channel, want.channel,
               got.min_value, want.min_value, got.max_value, want.max_value,
               got.last, want.last);
  endtask

  // Random receiver stall
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 18);
  end

  // Compare each point taken against the oldest expectation
  always @(posedge clk) begin : check_points
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      points_checked++;
      if (int'(out_data.level) > deepest) deepest = int'(out_data.level);
      if (points_due.size() == 0) begin
        flag("unexpected point", out_data, '0);
      end else begin
        want = points_due.pop_front();
        if (out_data.level !== want.level || out_data.channel !== want.channel ||
            out_data.min_value !== want.min_value || out_data.max_value !== want.max_value ||
            out_data.last !== want.last)
          flag("point differs", out_data, want);
      end
    end
  end

  // -------------------------------------------------------------------- main

  initial begin
    logic [CFG_DATA_W-1:0] ch_pick [5];
    logic [CFG_DATA_W-1:0] lv_pick [5];
    logic [CFG_DATA_W-1:0] ch_val, lv_val;
    int phase;
    ch_pick = '{4'd4, 4'd1, 4'd7, 4'd0, 4'd3};
    lv_pick = '{4'd10, 4'd1, 4'd15, 4'd0, 4'd2};

    chan_reg_m = CHANNEL_COUNT_RST;
    lvl_reg_m  = LEVEL_COUNT_RST;
    clear_envelope();

    // Opening script: reset registers first
    script.push_back(word_row(SMP_MIN, 1'b0));
    script.push_back(word_row(SMP_MAX, 1'b0));
    script.push_back(word_row(16'sd0, 1'b0));
    script.push_back(word_row(-16'sd1, 1'b0));
    script.push_back(word_row(16'sd1, 1'b0));
    script.push_back(word_row(16'sh4000, 1'b0));
    script.push_back(word_row(-16'sh4000, 1'b0));
    script.push_back(typed_row(16'sd5, 1'b0, mk_point(0, 0, SMP_MIN, SMP_MAX, 1'b1)));
    // end marker flushes the pending points through every level
    script.push_back(word_row(16'sd100, 1'b1));
    // level count zero acts as one
    script.push_back(reg_row(CFG_LEVEL_COUNT, 4'd0));
    script.push_back(typed_row(16'sd300, 1'b1, mk_point(0, 0, 16'sd300, 16'sd300, 1'b1)));
    // channel count zero acts as one
    script.push_back(reg_row(CFG_CHANNEL_COUNT, 4'd0));
    script.push_back(typed_row(-16'sd300, 1'b1, mk_point(0, 0, -16'sd300, -16'sd300, 1'b1)));
    // counts above range clamp to the maximum
    script.push_back(reg_row(CFG_CHANNEL_COUNT, 4'd7));
    script.push_back(reg_row(CFG_LEVEL_COUNT, 4'd15));
    // end marker inside an unfinished frame emits nothing
    script.push_back(word_row(16'sd11, 1'b0));
    script.push_back(word_row(16'sd33, 1'b1));
    // lower the channel count mid-frame: next sample restarts the frame
    script.push_back(word_row(16'sd44, 1'b0));
    script.push_back(word_row(16'sd55, 1'b0));
    script.push_back(reg_row(CFG_CHANNEL_COUNT, 4'd2));
    script.push_back(word_row(16'sd66, 1'b0));
    script.push_back(word_row(16'sd77, 1'b1));
    // end marker on the word that closes a window: no empty level-0 point
    script.push_back(reg_row(CFG_CHANNEL_COUNT, 4'd1));
    script.push_back(reg_row(CFG_LEVEL_COUNT, 4'd1));
    script.push_back(word_row(16'sh0F0F, 1'b0));
    script.push_back(word_row(-16'sd2, 1'b0));
    script.push_back(word_row(16'sd3, 1'b0));
    script.push_back(word_row(-16'sd4, 1'b0));
    script.push_back(word_row(16'sd5, 1'b0));
    script.push_back(word_row(-16'sd6, 1'b0));
    script.push_back(word_row(16'sd7, 1'b0));
    script.push_back(typed_row(-16'sd8, 1'b1, mk_point(0, 0, -16'sd8, 16'sh0F0F, 1'b1)));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        settle();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_word(script[i].w, script[i].typed, script[i].want);
      end
    end

    // Random phases: extremes of the registers first, then random settings
    phase = 0;
    while (words_sent < script.size() + RANDOM_WORDS) begin
      if (phase < 5) begin
        ch_val = ch_pick[phase];
        lv_val = lv_pick[phase];
      end else begin
        ch_val = CFG_DATA_W'($urandom_range(0, 7));
        lv_val = CFG_DATA_W'($urandom_range(0, 15));
      end
      settle();
      write_reg(CFG_CHANNEL_COUNT, ch_val);
      write_reg(CFG_LEVEL_COUNT, lv_val);
      calm = (phase == 2);
      repeat ($urandom_range(1, 2)) run_stream();
      phase++;
    end
    calm = 1'b0;

    settle();
    $display("Sent %0d sample words across %0d register writes; checked %0d points",
             words_sent, reg_writes, points_checked);
    $display("Deepest pyramid level seen: %0d", deepest);
    if (points_due.size() != 0) begin
      $display("ERROR %0d expected points never arrived", points_due.size());
      errors += points_due.size();
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("ERROR timeout with %0d points outstanding", points_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
